/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, prop, msg)

`define ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

/* sv/p32mul_pkg.sv */
// ----------------------------------------------------------------------------
// Posit multiplier package
// Operand class codes shared by the decoder and the top level.
// ----------------------------------------------------------------------------
package p32mul_pkg;

    // Operand class after decode
    typedef enum logic [2:0] {
        OP_NORMAL = 3'b001,
        OP_ZERO   = 3'b010,
        OP_NAR    = 3'b100
    } op_class_t;

endpackage

/* sv/p32mul_decode.sv */
// ----------------------------------------------------------------------------
// Posit operand decoder
// Splits one posit into sign, scale (regime and exponent) and significand.
// ----------------------------------------------------------------------------
module p32mul_decode #(
    parameter int POSIT_WIDTH = 32,
    parameter int EXP_BITS    = 4,
    localparam int W          = POSIT_WIDTH - 1,
    localparam int SIG_W      = POSIT_WIDTH - 2,
    localparam int SCALE_W    = $clog2(2 * W * (1 << EXP_BITS) + 2) + 1
) (
    input  logic [POSIT_WIDTH-1:0]    operand,
    output p32mul_pkg::op_class_t     op_class,
    output logic                      op_neg,
    output logic signed [SCALE_W-1:0] op_scale,
    output logic [SIG_W-1:0]          op_sig
);
    import p32mul_pkg::*;

    localparam int RUN_W = $clog2(W + 2);
    localparam int EW    = (EXP_BITS > 0) ? EXP_BITS : 1;
    localparam logic [POSIT_WIDTH-1:0] NAR_PAT = {1'b1, {W{1'b0}}};

    logic [POSIT_WIDTH-1:0]    body;
    logic [W-1:0]              body_w;
    logic [W-1:0]              scan;
    logic [W-1:0]              tail;
    logic [W-1:0]              frac_sh;
    logic                      r0;
    logic [RUN_W-1:0]          run;
    logic signed [SCALE_W-1:0] k_val;
    logic [EW-1:0]             e_val;

    always_comb begin
        op_neg = operand[POSIT_WIDTH-1];
        body   = op_neg ? -operand : operand;
        body_w = body[W-1:0];
        r0     = body_w[W-1];
        scan   = r0 ? ~body_w : body_w;

        // Run length of the regime: leading bits equal to the first one
        run = RUN_W'(W);
        for (int i = 0; i < W; i++) begin
            if (scan[i]) begin
                run = RUN_W'(W - 1 - i);
            end
        end

        // Drop regime and terminator, exponent then fraction left-aligned
        tail    = body_w << (run + 1'b1);
        e_val   = EW'(tail >> (W - EXP_BITS));
        frac_sh = tail << EXP_BITS;

        if (r0) begin
            k_val = $signed(SCALE_W'(run)) - $signed(SCALE_W'(1));
        end else begin
            k_val = -$signed(SCALE_W'(run));
        end
        op_scale = (k_val <<< EXP_BITS) + $signed(SCALE_W'(e_val));
        op_sig   = {1'b1, frac_sh[W-1:2]};

        if (operand == '0) begin
            op_class = OP_ZERO;
        end else if (operand == NAR_PAT) begin
            op_class = OP_NAR;
        end else begin
            op_class = OP_NORMAL;
        end
    end

endmodule

/* sv/posit32_es4_multiplier_unit.sv */
// ----------------------------------------------------------------------------
// Posit multiplier unit
// Registered product of two posits with truncated fraction and range clamp.
// ----------------------------------------------------------------------------
// Takes one operand pair per beat and returns one product beat per pair, in
// order. Operands are posit<POSIT_WIDTH, EXP_BITS> patterns in the low
// POSIT_WIDTH bits of each 32-bit port (upper bits are ignored, upper product
// bits read zero). NaR in either operand gives NaR with m_is_nar set, also
// when the other operand is zero; otherwise a zero operand gives zero. The
// fraction is truncated, never rounded, and the magnitude is clamped to
// minpos/maxpos, so a nonzero product never underflows to zero. A pair is
// loaded into the input register at its accepting edge; decode, significand
// multiply and repack then run as one combinational pass into the result
// register, which offers the product beat. A new pair is accepted every
// cycle while the result side keeps up; s_ready drops only when both
// registers are full and m_ready is low. The decode, the significand
// multiply (POSIT_WIDTH-2 bits square) and the repack form one path and
// set the clock period.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module posit32_es4_multiplier_unit #(
    parameter int POSIT_WIDTH = 32,
    parameter int EXP_BITS    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_product,
    output logic        m_is_nar
);
    import p32mul_pkg::*;

    localparam int W       = POSIT_WIDTH - 1;
    localparam int SIG_W   = POSIT_WIDTH - 2;
    localparam int PROD_W  = 2 * SIG_W;
    localparam int SCALE_W = $clog2(2 * W * (1 << EXP_BITS) + 2) + 1;
    localparam int RUN_W   = $clog2(W + 2);
    localparam int EW      = (EXP_BITS > 0) ? EXP_BITS : 1;
    localparam logic [EW-1:0] EXP_MASK = EW'((1 << EXP_BITS) - 1);
    localparam logic [31:0] NAR_WORD   = 32'd1 << (POSIT_WIDTH - 1);
    localparam logic signed [SCALE_W-1:0] LIMIT_POS = SCALE_W'(POSIT_WIDTH - 2);
    localparam logic signed [SCALE_W-1:0] LIMIT_NEG = -LIMIT_POS;

    // Ready chain: a register advances when empty or when the next advances
    logic s0_ready, s1_ready;

    // Input register
    logic                   s0_valid_reg;
    logic [POSIT_WIDTH-1:0] s0_a_reg, s0_b_reg;

    // Result register
    logic        m_valid_reg;
    logic [31:0] m_product_reg, m_product_next;
    logic        m_is_nar_reg;

    // Decoder outputs
    op_class_t                 cls_a, cls_b;
    logic                      neg_a, neg_b;
    logic signed [SCALE_W-1:0] scale_a, scale_b;
    logic [SIG_W-1:0]          sig_a, sig_b;

    // Combined operands and raw significand product
    logic                      prod_nar, prod_zero, prod_neg;
    logic signed [SCALE_W-1:0] prod_scale;
    logic [PROD_W-1:0]         prod_sig;

    // Pack signals
    logic signed [SCALE_W-1:0] scale_n, k_p;
    logic [PROD_W-1:0]         frac_al;
    logic [W-1:0]              frac_w, tail_p, regime, mag;
    logic [EW-1:0]             e_p;
    logic [RUN_W-1:0]          amt, used;
    logic [POSIT_WIDTH-1:0]    res;

    assign s1_ready = !m_valid_reg || m_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign s_ready  = s0_ready;

    p32mul_decode #(.POSIT_WIDTH(POSIT_WIDTH), .EXP_BITS(EXP_BITS)) u_dec_a (
        .operand  (s0_a_reg),
        .op_class (cls_a),
        .op_neg   (neg_a),
        .op_scale (scale_a),
        .op_sig   (sig_a)
    );

    p32mul_decode #(.POSIT_WIDTH(POSIT_WIDTH), .EXP_BITS(EXP_BITS)) u_dec_b (
        .operand  (s0_b_reg),
        .op_class (cls_b),
        .op_neg   (neg_b),
        .op_scale (scale_b),
        .op_sig   (sig_b)
    );

    // Control: valid bits of the two registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s0_ready) begin
                s0_valid_reg <= s_valid;
            end
            if (s1_ready) begin
                m_valid_reg <= s0_valid_reg;
            end
        end
    end

    // Datapath: load a register only when a beat moves into it
    always_ff @(posedge aclk) begin
        if (s0_ready && s_valid) begin
            s0_a_reg <= s_operand_a[POSIT_WIDTH-1:0];
            s0_b_reg <= s_operand_b[POSIT_WIDTH-1:0];
        end
        if (s1_ready && s0_valid_reg) begin
            m_product_reg <= m_product_next;
            m_is_nar_reg  <= prod_nar;
        end
    end

    // Combine the decoded operands and multiply the significands
    assign prod_nar   = (cls_a == OP_NAR) || (cls_b == OP_NAR);
    assign prod_zero  = (cls_a == OP_ZERO) || (cls_b == OP_ZERO);
    assign prod_neg   = neg_a ^ neg_b;
    assign prod_scale = scale_a + scale_b;
    assign prod_sig   = PROD_W'(sig_a) * PROD_W'(sig_b);

    // Pack: renormalize, split scale into regime and exponent, clamp, repack
    always_comb begin
        // Product lies in [1, 4): a carry into the top bit bumps the scale
        scale_n = prod_scale + $signed(SCALE_W'(prod_sig[PROD_W-1]));
        // Drop the hidden one and left-align the fraction
        frac_al = prod_sig[PROD_W-1] ? (prod_sig << 1) : (prod_sig << 2);
        frac_w  = frac_al[PROD_W-1 -: W];

        k_p    = scale_n >>> EXP_BITS;
        e_p    = EW'(scale_n) & EXP_MASK;
        tail_p = (W'(e_p) << (W - EXP_BITS)) | (frac_w >> EXP_BITS);

        amt    = '0;
        used   = '0;
        regime = '0;
        if (k_p >= LIMIT_POS) begin
            mag = {W{1'b1}};
        end else if (k_p < LIMIT_NEG) begin
            mag = W'(1);
        end else begin
            if (k_p >= 0) begin
                // k+1 ones, then a terminating zero
                amt    = RUN_W'(k_p);
                regime = ~({W{1'b1}} >> (amt + 1'b1));
                used   = amt + RUN_W'(2);
            end else begin
                // -k zeros, then a terminating one
                amt    = RUN_W'(-k_p);
                regime = {1'b1, {(W - 1){1'b0}}} >> amt;
                used   = amt + RUN_W'(1);
            end
            mag = regime | (tail_p >> used);
        end

        res = prod_neg ? -{1'b0, mag} : {1'b0, mag};

        if (prod_nar) begin
            m_product_next = NAR_WORD;
        end else if (prod_zero) begin
            m_product_next = '0;
        end else begin
            m_product_next = 32'(res);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_product = m_product_reg;
    assign m_is_nar  = m_is_nar_reg;

    `ASSERT_ALWAYS(a_nar_match, aclk, aresetn,
        m_valid |-> (m_is_nar == (m_product == NAR_WORD)),
        "NaR flag and pattern disagree")
    `ASSERT_NEVER(a_high_clear, aclk, aresetn,
        m_valid && ((m_product >> POSIT_WIDTH) != '0),
        "product bits above width set")
    `ASSERT_ALWAYS(a_prod_norm, aclk, aresetn,
        (s0_valid_reg && !prod_nar && !prod_zero) |->
            (prod_sig[PROD_W-1] || prod_sig[PROD_W-2]),
        "product not normalized")
    `ASSERT_ALWAYS(a_accept_load, aclk, aresetn,
        (s_valid && s_ready) |=> s0_valid_reg,
        "accepted beat not held")

endmodule
